// File: hdl/fixed_width_dictionary_unpacker_top_assert.svh
// Assertion macros used by the checker file.
`ifndef FIXED_WIDTH_DICTIONARY_UNPACKER_TOP_ASSERT_SVH
`define FIXED_WIDTH_DICTIONARY_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FWDU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwdu assertion failed");

// Next-cycle implication.
`define FWDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwdu assertion failed");

`endif

// File: hdl/fwdu_pkg.sv
package fwdu_pkg;

    localparam int FIRST_DATA_BITS = 5;
    localparam int PAD_FIELD_BITS  = 3;
    localparam int BYTE_BITS       = 8;

    // Stream phase
    typedef enum logic [1:0] {
        PH_COUNT,
        PH_DICT,
        PH_FIRST,
        PH_DATA
    } phase_t;

    // Microprogram addresses
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_COUNT,
        ST_DICT,
        ST_BIT,
        ST_EMIT,
        ST_END
    } step_t;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_COUNT,
        OP_DICT,
        OP_SHIFT,
        OP_EMIT,
        OP_END
    } op_t;

    // Sequencing rule of one step
    typedef enum logic [1:0] {
        SEQ_GOTO,
        SEQ_DISPATCH,
        SEQ_BIT,
        SEQ_EMIT
    } seq_t;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        step_t target;
    } ctrl_word_t;

    // Datapath conditions seen by the sequencer
    typedef struct packed {
        logic   in_fire;
        phase_t phase;
        logic   data_empty;
        logic   code_done;
        logic   more_after_shift;
        logic   more_bits;
        logic   out_free;
    } status_t;

    // Control store
    function automatic ctrl_word_t ucode_rom(input step_t addr);
        ctrl_word_t w;
        unique case (addr)
            ST_FETCH: w = '{op: OP_FETCH, seq: SEQ_DISPATCH, target: ST_FETCH};
            ST_COUNT: w = '{op: OP_COUNT, seq: SEQ_GOTO,     target: ST_END};
            ST_DICT:  w = '{op: OP_DICT,  seq: SEQ_GOTO,     target: ST_END};
            ST_BIT:   w = '{op: OP_SHIFT, seq: SEQ_BIT,      target: ST_EMIT};
            ST_EMIT:  w = '{op: OP_EMIT,  seq: SEQ_EMIT,     target: ST_BIT};
            ST_END:   w = '{op: OP_END,   seq: SEQ_GOTO,     target: ST_FETCH};
            default:  w = '{op: OP_END,   seq: SEQ_GOTO,     target: ST_FETCH};
        endcase
        return w;
    endfunction

    // Bit length of an 8-bit value
    function automatic logic [3:0] bit_length(input logic [7:0] m);
        logic [3:0] w;
        w = 4'd0;
        for (int i = 0; i < BYTE_BITS; i++) begin
            if (m[i]) begin
                w = 4'(i + 1);
            end
        end
        return w;
    endfunction

endpackage

// File: hdl/fixed_width_dictionary_unpacker_top.sv
// Fixed-width dictionary unpacker.
// Input stream s_axis: one compressed byte per word; tlast marks the final byte.
// The first byte of a stream is the symbol count (0 means 256), then that many
// dictionary bytes, then packed codes MSB first; the top 3 bits of the first
// data byte give the padding bits dropped from the final byte.
// Output stream m_axis: one decoded symbol per word; tlast marks the last
// symbol produced by an input byte, tuser the last symbol of the stream.
// Timing: a microcoded sequencer handles one input byte at a time. A count or
// dictionary byte passes through the fetch step, its own step and the end step.
// A data byte passes through fetch, a shift step per code bit (at most 8) with
// an emit step after each completed code, then the end step; the shift step
// gathers one code bit per cycle and the emit step sends one symbol per cycle
// while the output register is free.
// A stalled receiver holds the output register and freezes the sequencer in
// its emit step; the next byte may be accepted while the final symbol waits.
// Reset returns the block to expecting a count byte; the dictionary memory is
// not cleared and is always written before use within a stream.
module fixed_width_dictionary_unpacker_top
    import fwdu_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] symbol
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] stream_done
);

    localparam int AW = $clog2(TABLE_DEPTH);

    ctrl_word_t      ctrl;
    status_t         status;
    logic            ram_we;
    logic [AW-1:0]   ram_wr_addr;
    logic [7:0]      ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    logic [7:0]      ram_rd_data;

    fwdu_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    fwdu_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .ram_we        (ram_we),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    fwdu_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_dict (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: hdl/fwdu_ram.sv
module fwdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/fwdu_seq.sv
module fwdu_seq
    import fwdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  status_t    status,
    output ctrl_word_t ctrl
);

    step_t pc_reg;
    step_t pc_next;

    assign ctrl = ucode_rom(pc_reg);

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Jump logic
    always_comb
    begin
        pc_next = ctrl.target;
        unique case (ctrl.seq)
            SEQ_GOTO: pc_next = ctrl.target;
            SEQ_DISPATCH:
            begin
                if (!status.in_fire)
                begin
                    pc_next = pc_reg;
                end
                else
                begin
                    case (status.phase)
                        PH_COUNT: pc_next = ST_COUNT;
                        PH_DICT:  pc_next = ST_DICT;
                        default:  pc_next = status.data_empty ? ST_END : ST_BIT;
                    endcase
                end
            end
            SEQ_BIT:
            begin
                if (status.code_done)
                begin
                    pc_next = ctrl.target;
                end
                else if (status.more_after_shift)
                begin
                    pc_next = ST_BIT;
                end
                else
                begin
                    pc_next = ST_END;
                end
            end
            SEQ_EMIT:
            begin
                if (!status.out_free)
                begin
                    pc_next = pc_reg;
                end
                else if (status.more_bits)
                begin
                    pc_next = ctrl.target;
                end
                else
                begin
                    pc_next = ST_END;
                end
            end
            default: pc_next = ST_FETCH;
        endcase
    end

endmodule

// File: hdl/fwdu_dp.sv
module fwdu_dp
    import fwdu_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctrl_word_t                     ctrl,
    output status_t                        status,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,
    input  logic                           s_axis_tlast,
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tuser,
    // Dictionary memory
    output logic                           ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
    output logic [7:0]                     ram_wr_data,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
    input  logic [7:0]                     ram_rd_data
);

    localparam int         AW        = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

    phase_t      phase_reg, phase_next;
    logic [8:0]  count_reg, count_next;
    logic [8:0]  fill_reg, fill_next;
    logic [3:0]  width_reg, width_next;
    logic [7:0]  partial_reg, partial_next;
    logic [3:0]  pbits_reg, pbits_next;
    logic [2:0]  pad_reg, pad_next;
    logic [3:0]  rem_reg, rem_next;
    logic        last_reg, last_next;
    logic        run_last_reg, run_last_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  sym_reg, sym_next;
    logic        tlast_reg, tlast_next;
    logic        tuser_reg, tuser_next;

    logic        in_fire;
    logic        out_free;
    logic        data_empty;
    logic [2:0]  first_lo;
    logic [3:0]  first_rem;
    logic [2:0]  data_lo;
    logic [3:0]  data_rem;
    logic [7:0]  code_shifted;
    logic [3:0]  pbits_inc;
    logic [3:0]  rem_dec;
    logic        code_done;
    logic        in_range;

    assign s_axis_tready = (ctrl.op == OP_FETCH);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Bit budget of an incoming data word
    assign first_lo   = s_axis_tlast ? s_axis_tdata[7:5] : 3'd0;
    assign data_empty = (phase_reg == PH_FIRST) && s_axis_tlast
                        && (s_axis_tdata[7:5] >= 3'(FIRST_DATA_BITS));
    assign first_rem  = 4'(FIRST_DATA_BITS) - {1'b0, first_lo};
    assign data_lo    = s_axis_tlast ? pad_reg : 3'd0;
    assign data_rem   = 4'(BYTE_BITS) - {1'b0, data_lo};

    // One code bit per shift step, MSB first
    assign code_shifted = {partial_reg[6:0], shift_reg[7]};
    assign pbits_inc    = pbits_reg + 4'd1;
    assign rem_dec      = rem_reg - 4'd1;
    assign code_done    = (pbits_inc >= width_reg);

    assign in_range = ({1'b0, code_reg} < count_reg) && ({1'b0, code_reg} < DEPTH_LIM);

    assign status = '{
        in_fire:          in_fire,
        phase:            phase_reg,
        data_empty:       data_empty,
        code_done:        code_done,
        more_after_shift: (rem_dec != 4'd0),
        more_bits:        (rem_reg != 4'd0),
        out_free:         out_free
    };

    // Dictionary port
    assign ram_wr_addr = fill_reg[AW-1:0];
    assign ram_wr_data = shift_reg;
    assign ram_rd_addr = code_next[AW-1:0];

    // Step operations
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        width_next    = width_reg;
        partial_next  = partial_reg;
        pbits_next    = pbits_reg;
        pad_next      = pad_reg;
        rem_next      = rem_reg;
        last_next     = last_reg;
        run_last_next = run_last_reg;
        shift_next    = shift_reg;
        code_next     = code_reg;
        sym_next      = sym_reg;
        tlast_next    = tlast_reg;
        tuser_next    = tuser_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        ram_we        = 1'b0;

        unique case (ctrl.op)
            OP_FETCH:
            begin
                if (in_fire)
                begin
                    last_next = s_axis_tlast;
                    if (phase_reg == PH_FIRST)
                    begin
                        shift_next = {s_axis_tdata[4:0], 3'b000};
                        pad_next   = s_axis_tdata[7:5];
                        rem_next   = data_empty ? 4'd0 : first_rem;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        shift_next = s_axis_tdata;
                        rem_next   = data_rem;
                    end
                end
            end
            OP_COUNT:
            begin
                count_next   = (shift_reg == 8'd0) ? 9'd256 : {1'b0, shift_reg};
                width_next   = (bit_length(shift_reg - 8'd1) == 4'd0)
                               ? 4'd1 : bit_length(shift_reg - 8'd1);
                fill_next    = 9'd0;
                partial_next = 8'd0;
                pbits_next   = 4'd0;
                phase_next   = PH_DICT;
            end
            OP_DICT:
            begin
                ram_we    = (fill_reg < DEPTH_LIM);
                fill_next = fill_reg + 9'd1;
                if (fill_next >= count_reg)
                begin
                    phase_next = PH_FIRST;
                end
            end
            OP_SHIFT:
            begin
                shift_next = {shift_reg[6:0], 1'b0};
                rem_next   = rem_dec;
                if (code_done)
                begin
                    code_next     = code_shifted;
                    run_last_next = (rem_dec < width_reg);
                    partial_next  = 8'd0;
                    pbits_next    = 4'd0;
                end
                else
                begin
                    partial_next = code_shifted;
                    pbits_next   = pbits_inc;
                end
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    sym_next     = in_range ? ram_rd_data : 8'd0;
                    tlast_next   = run_last_reg;
                    tuser_next   = run_last_reg & last_reg;
                end
            end
            OP_END:
            begin
                if (last_reg)
                begin
                    phase_next   = PH_COUNT;
                    partial_next = 8'd0;
                    pbits_next   = 4'd0;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            count_reg    <= 9'd0;
            fill_reg     <= 9'd0;
            width_reg    <= 4'd0;
            partial_reg  <= 8'd0;
            pbits_reg    <= 4'd0;
            pad_reg      <= 3'd0;
            rem_reg      <= 4'd0;
            last_reg     <= 1'b0;
            run_last_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            width_reg    <= width_next;
            partial_reg  <= partial_next;
            pbits_reg    <= pbits_next;
            pad_reg      <= pad_next;
            rem_reg      <= rem_next;
            last_reg     <= last_next;
            run_last_reg <= run_last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        code_reg  <= code_next;
        sym_reg   <= sym_next;
        tlast_reg <= tlast_next;
        tuser_reg <= tuser_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = sym_reg;
    assign m_axis_tlast  = tlast_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

// File: hdl/fwdu_checker.sv
`include "fixed_width_dictionary_unpacker_top_assert.svh"

module fwdu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    logic in_fire;
    logic out_stall;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled output word holds
    `FWDU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // The sequencer is not ready again in the cycle after it takes a byte
    `FWDU_ASSERT_NEXT(a_busy_after_fetch, clk, rst_n, in_fire, !s_axis_tready)

    // A new symbol never appears the cycle right after a byte is taken
    `FWDU_ASSERT_IMPLY(a_no_instant_symbol, clk, rst_n,
        $rose(m_axis_tvalid), !$past(in_fire))

    // End of stream is always also the last symbol of its byte
    `FWDU_ASSERT_IMPLY(a_done_is_last, clk, rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tlast)

endmodule

bind fixed_width_dictionary_unpacker_top fwdu_checker u_fwdu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
